FILE: design/subtractive_lagged_random_generator_macros.svh
// Assertion macros for the subtractive lagged random generator.
// Both forms are empty when SYNTH is defined.
`ifndef SUBTRACTIVE_LAGGED_RANDOM_GENERATOR_MACROS_SVH
`define SUBTRACTIVE_LAGGED_RANDOM_GENERATOR_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define SLRG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slrg: same-cycle check failed");
// next-cycle implication
`define SLRG_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slrg: next-cycle check failed");
`else
`define SLRG_ASSERT_IMP(label, clk, rst, ante, cons)
`define SLRG_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: design/slrg_pkg.sv
package slrg_pkg;

   // field and table geometry
   localparam int unsigned VALUE_W   = 30;
   localparam int unsigned SEED_W    = 28;
   localparam int unsigned TABLE_LEN = 55;
   localparam int unsigned SLOT_W    = 6;
   localparam int unsigned STEP_W    = 3;
   localparam int unsigned CNT_W     = 8;

   localparam logic [VALUE_W-1:0] MOD_BIG     = 30'd1000000000;
   localparam logic [SEED_W-1:0]  SEED_BASE   = 28'd161803398;
   localparam logic [SLOT_W-1:0]  FILL_STRIDE = 6'd21;
   localparam logic [SLOT_W-1:0]  LAG_OFFSET  = 6'd31;
   localparam logic [SLOT_W-1:0]  LAST_SLOT   = 6'd54;
   localparam logic [SLOT_W:0]    LEN_WIDE    = 7'd55;

   // loop counts (iterations minus one)
   localparam logic [CNT_W-1:0] CNT_FILL = 8'd53;
   localparam logic [CNT_W-1:0] CNT_WARM = 8'd219;

   // datapath operations
   typedef logic [2:0] op_type;
   localparam op_type OP_TAKE   = 3'd0;
   localparam op_type OP_SEED   = 3'd1;
   localparam op_type OP_FILL   = 3'd2;
   localparam op_type OP_WSET   = 3'd3;
   localparam op_type OP_WAIT   = 3'd4;
   localparam op_type OP_UPDATE = 3'd5;
   localparam op_type OP_MARK   = 3'd6;
   localparam op_type OP_GEN    = 3'd7;

   // jump kinds
   typedef logic [1:0] jump_type;
   localparam jump_type JMP_NEXT = 2'd0;
   localparam jump_type JMP_LOOP = 2'd1;
   localparam jump_type JMP_REQ  = 2'd2;
   localparam jump_type JMP_OUT  = 2'd3;

   // loop counter load select
   typedef logic [1:0] cnt_sel_type;
   localparam cnt_sel_type CNT_SEL_HOLD = 2'd0;
   localparam cnt_sel_type CNT_SEL_FILL = 2'd1;
   localparam cnt_sel_type CNT_SEL_WARM = 2'd2;

   // program steps
   typedef logic [STEP_W-1:0] step_type;
   localparam step_type STEP_IDLE = 3'd0;
   localparam step_type STEP_SEED = 3'd1;
   localparam step_type STEP_FILL = 3'd2;
   localparam step_type STEP_WSET = 3'd3;
   localparam step_type STEP_WAIT = 3'd4;
   localparam step_type STEP_WARM = 3'd5;
   localparam step_type STEP_MARK = 3'd6;
   localparam step_type STEP_GEN  = 3'd7;

   typedef struct packed {
      op_type      op;
      jump_type    jump;
      step_type    target;
      cnt_sel_type cnt_sel;
   } ctrl_word_type;

   // sequencer to datapath
   typedef struct packed {
      op_type op;
      logic   go;
   } dp_ctrl_type;

   // datapath to sequencer
   typedef struct packed {
      logic need_build;
      logic out_busy;
   } dp_stat_type;

   // control store
   function automatic ctrl_word_type ctrl_rom(input step_type step);
      ctrl_word_type word;
      unique case (step)
         STEP_IDLE: word = '{op: OP_TAKE,   jump: JMP_REQ,  target: STEP_GEN,
                             cnt_sel: CNT_SEL_HOLD};
         STEP_SEED: word = '{op: OP_SEED,   jump: JMP_NEXT, target: STEP_IDLE,
                             cnt_sel: CNT_SEL_FILL};
         STEP_FILL: word = '{op: OP_FILL,   jump: JMP_LOOP, target: STEP_FILL,
                             cnt_sel: CNT_SEL_HOLD};
         STEP_WSET: word = '{op: OP_WSET,   jump: JMP_NEXT, target: STEP_IDLE,
                             cnt_sel: CNT_SEL_WARM};
         STEP_WAIT: word = '{op: OP_WAIT,   jump: JMP_NEXT, target: STEP_IDLE,
                             cnt_sel: CNT_SEL_HOLD};
         STEP_WARM: word = '{op: OP_UPDATE, jump: JMP_LOOP, target: STEP_WAIT,
                             cnt_sel: CNT_SEL_HOLD};
         STEP_MARK: word = '{op: OP_MARK,   jump: JMP_NEXT, target: STEP_IDLE,
                             cnt_sel: CNT_SEL_HOLD};
         STEP_GEN:  word = '{op: OP_GEN,    jump: JMP_OUT,  target: STEP_IDLE,
                             cnt_sel: CNT_SEL_HOLD};
      endcase
      return word;
   endfunction

   // (a - b) mod 10^9, both operands below 10^9
   function automatic logic [VALUE_W-1:0] sub_mod(input logic [VALUE_W-1:0] a,
                                                  input logic [VALUE_W-1:0] b);
      logic [VALUE_W:0] diff;
      diff = {1'b0, a} - {1'b0, b};
      if (diff[VALUE_W]) begin
         return diff[VALUE_W-1:0] + MOD_BIG;
      end
      return diff[VALUE_W-1:0];
   endfunction

endpackage

FILE: design/subtractive_lagged_random_generator.sv
// Request path: a transfer leads to the generate step, which loads the result register.
// Requests: a new one is taken only back in the idle step, after the generate step has run.
// Rebuild: 54 fill writes, then 220 warm-up updates, each after a wait step, on the same RAM port.
// Reset: sequencer idle, lead slot 0, unseeded, no result pending; the table is not cleared
// and the first request after reset always rebuilds it.
`include "subtractive_lagged_random_generator_macros.svh"
module subtractive_lagged_random_generator import slrg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_reseed,
   input  logic [SEED_W-1:0]  req_seed_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [VALUE_W-1:0] rsp_random_value
);

   dp_ctrl_type        ctrl;
   dp_stat_type        stat;
   logic               wr_en;
   logic [SLOT_W-1:0]  wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [SLOT_W-1:0]  rd_addr_a;
   logic [SLOT_W-1:0]  rd_addr_b;
   logic [VALUE_W-1:0] rd_data_a;
   logic [VALUE_W-1:0] rd_data_b;

   // program sequencer
   slrg_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .ctrl      (ctrl),
      .req_stall (req_stall)
   );

   // arithmetic, indices and result register
   slrg_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stat             (stat),
      .req_reseed       (req_reseed),
      .req_seed_value   (req_seed_value),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rd_addr_a        (rd_addr_a),
      .rd_addr_b        (rd_addr_b),
      .rd_data_a        (rd_data_a),
      .rd_data_b        (rd_data_b),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_random_value (rsp_random_value)
   );

   // 55-word lag table
   slrg_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TABLE_LEN)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // a request transfer always takes the block out of idle
   `SLRG_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)
   // a generate step always leaves a result pending
   `SLRG_ASSERT_NXT(a_gen_loads_rsp, clock, reset, ctrl.go && (ctrl.op == OP_GEN), rsp_valid)
   // every result is a residue modulo 10^9
   `SLRG_ASSERT_IMP(a_rsp_in_range, clock, reset, rsp_valid, rsp_random_value < MOD_BIG)

endmodule

FILE: design/slrg_ram.sv
module slrg_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [WIDTH-1:0]  rd_data_a,
   output logic [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: design/slrg_seq.sv
module slrg_seq import slrg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  dp_stat_type stat,
   output dp_ctrl_type ctrl,
   output logic        req_stall
);

   step_type          step_ff, step_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   ctrl_word_type     word;
   logic              go;

   // fetch, branch and loop count
   always_comb begin
      word    = ctrl_rom(step_ff);
      go      = 1'b1;
      step_in = step_ff;
      cnt_in  = cnt_ff;
      unique case (word.jump)
         JMP_NEXT: begin
            step_in = step_ff + 1'b1;
         end
         JMP_LOOP: begin
            if (cnt_ff != '0) begin
               step_in = word.target;
               cnt_in  = cnt_ff - 1'b1;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         JMP_REQ: begin
            go = req_valid;
            if (req_valid) begin
               step_in = stat.need_build ? step_type'(step_ff + 1'b1) : word.target;
            end
         end
         JMP_OUT: begin
            go = !stat.out_busy;
            if (go) begin
               step_in = word.target;
            end
         end
      endcase
      if (go) begin
         unique case (word.cnt_sel)
            CNT_SEL_FILL: cnt_in = CNT_FILL;
            CNT_SEL_WARM: cnt_in = CNT_WARM;
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
         cnt_ff  <= '0;
      end else begin
         step_ff <= step_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign ctrl.op   = word.op;
   assign ctrl.go   = go;
   assign req_stall = (step_ff != STEP_IDLE);

endmodule

FILE: design/slrg_dp.sv
module slrg_dp import slrg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  dp_ctrl_type        ctrl,
   output dp_stat_type        stat,
   input  logic               req_reseed,
   input  logic [SEED_W-1:0]  req_seed_value,
   output logic               wr_en,
   output logic [SLOT_W-1:0]  wr_addr,
   output logic [VALUE_W-1:0] wr_data,
   output logic [SLOT_W-1:0]  rd_addr_a,
   output logic [SLOT_W-1:0]  rd_addr_b,
   input  logic [VALUE_W-1:0] rd_data_a,
   input  logic [VALUE_W-1:0] rd_data_b,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [VALUE_W-1:0] rsp_random_value
);

   logic [SEED_W-1:0]  seed_ff, seed_in;
   logic [VALUE_W-1:0] prev_ff, prev_in;
   logic [VALUE_W-1:0] cur_ff, cur_in;
   logic [SLOT_W-1:0]  pos_ff, pos_in;
   logic [SLOT_W-1:0]  ptr_ff, ptr_in;
   logic               seeded_ff, seeded_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   logic [SEED_W-1:0]  seed_clamped;
   logic [SEED_W-1:0]  seed_diff;
   logic [SLOT_W:0]    fill_sum;
   logic [SLOT_W-1:0]  pos_next;
   logic [SLOT_W:0]    trail_sum;
   logic [SLOT_W-1:0]  trail_slot;
   logic [SLOT_W-1:0]  ptr_next;
   logic [VALUE_W-1:0] update_value;
   logic [VALUE_W-1:0] fill_next;

   // seed start value, clamped so the difference stays non-negative
   assign seed_clamped = (seed_ff > SEED_BASE) ? SEED_BASE : seed_ff;
   assign seed_diff    = SEED_BASE - seed_clamped;

   // stride-21 fill position, 1..54
   assign fill_sum = {1'b0, pos_ff} + {1'b0, FILL_STRIDE};
   assign pos_next = (fill_sum >= LEN_WIDE) ? SLOT_W'(fill_sum - LEN_WIDE)
                                            : fill_sum[SLOT_W-1:0];

   // lead slot and the trailing slot 31 places on
   assign trail_sum  = {1'b0, ptr_ff} + {1'b0, LAG_OFFSET};
   assign trail_slot = (trail_sum >= LEN_WIDE) ? SLOT_W'(trail_sum - LEN_WIDE)
                                               : trail_sum[SLOT_W-1:0];
   assign ptr_next   = (ptr_ff == LAST_SLOT) ? '0 : SLOT_W'(ptr_ff + 1'b1);

   assign update_value = sub_mod(rd_data_a, rd_data_b);
   assign fill_next    = sub_mod(prev_ff, cur_ff);

   // table reads run every cycle at the current slots
   assign rd_addr_a = ptr_ff;
   assign rd_addr_b = trail_slot;

   // operation decode
   always_comb begin
      seed_in      = seed_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      pos_in       = pos_ff;
      ptr_in       = ptr_ff;
      seeded_in    = seeded_ff;
      rsp_value_in = rsp_value_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = ptr_ff;
      wr_data      = update_value;
      unique case (ctrl.op) inside
         OP_TAKE: begin
            if (ctrl.go) begin
               seed_in = req_seed_value;
            end
         end
         OP_SEED: begin
            wr_en   = ctrl.go;
            wr_addr = LAST_SLOT;
            wr_data = VALUE_W'(seed_diff);
            prev_in = VALUE_W'(seed_diff);
            cur_in  = VALUE_W'(1);
            pos_in  = FILL_STRIDE;
         end
         OP_FILL: begin
            wr_en   = ctrl.go;
            wr_addr = pos_ff - 1'b1;
            wr_data = cur_ff;
            cur_in  = fill_next;
            prev_in = cur_ff;
            pos_in  = pos_next;
         end
         OP_WSET: begin
            ptr_in = '0;
         end
         OP_WAIT: begin
         end
         OP_UPDATE, OP_GEN: begin
            if (ctrl.go) begin
               wr_en  = 1'b1;
               ptr_in = ptr_next;
               if (ctrl.op == OP_GEN) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = update_value;
               end
            end
         end
         OP_MARK: begin
            seeded_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ptr_ff       <= ptr_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seed_ff      <= seed_in;
      prev_ff      <= prev_in;
      cur_ff       <= cur_in;
      pos_ff       <= pos_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign stat.need_build = req_reseed || !seeded_ff;
   assign stat.out_busy   = rsp_valid_ff && rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_value_ff;

endmodule
